@@ rtl/page_slot_bitmap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page slot bitmap allocator
// Clocked on aclk; the first form is masked while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define PSBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PSBA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PSBA_ASSERT(lbl, prop, msg)
`define PSBA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/psba_pkg.sv @@
// ----------------------------------------------------------------------------
// psba_pkg
// Types, codes and sizes shared by the page slot bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psba_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 4096;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BIT_W      = 6;
    localparam int unsigned PAGE_W     = 17;
    localparam int unsigned REC_W      = 13;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam int unsigned DIVIDEND_W = 20;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned REM_W      = 17;
    localparam int unsigned DIV_STEPS  = 20;
    localparam int unsigned DIV_CNT_W  = 5;

    localparam logic [PAGE_W-1:0]     PAGE_RST  = 17'd4096;
    localparam logic [REC_W-1:0]      REC_RST   = 13'd64;
    localparam logic [DIVIDEND_W-1:0] HDR_BITS  = 20'd32;
    localparam logic [PAGE_W-1:0]     PAGE_MIN  = 17'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 2'd1;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_MARK  = 3'd2;
    localparam logic [2:0] OP_QUERY = 3'd3;
    localparam logic [2:0] OP_COUNT = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_MEM,
        S_DONE
    } psba_state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [11:0] slot_sel;
    } psba_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] slot_found;
        logic [15:0] byte_offset;
        logic        slot_filled;
        logic [12:0] free_count;
        logic [12:0] slot_capacity;
    } psba_out_t;

endpackage

`default_nettype wire

@@ rtl/psba_ram.sv @@
// ----------------------------------------------------------------------------
// psba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module psba_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/page_slot_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// page_slot_bitmap_allocator
// Occupancy bitmap of one fixed-record page: clear, add to first free slot,
// mark, query and free count, with the slot capacity derived from the layout.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  cfg      in         cfg_we                  cfg_index, cfg_wdata
//  s        in         s_valid / s_ready       s_item  (opcode, slot_sel)
//  m        out        m_valid / m_ready       m_item  (status .. slot_capacity)
//
//  Clear, count and rejected requests go straight to the done state; mark and
//  query read one bitmap word first; add scans one word per cycle, up to
//  MAX_SLOTS/64 words (rounded up), a rate set by the single read port of the
//  bitmap RAM. After reset or a config write, a 1-bit-per-cycle divider works
//  out the capacity before s_ready rises; the bitmap is emptied at once.
//  A result holds in the output register until taken; the next one waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_slot_bitmap_allocator_defines.svh"

module page_slot_bitmap_allocator #(
    parameter int unsigned MAX_SLOTS = psba_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [psba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire psba_pkg::psba_in_t              s_item,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output psba_pkg::psba_out_t                  m_item
);

    import psba_pkg::*;

    localparam int unsigned ROWS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CAP_W  = $clog2(MAX_SLOTS + 1);

    psba_state_t             state_reg, state_next;
    logic                    dirty_reg, dirty_next;
    logic [PAGE_W-1:0]       page_bytes_reg;
    logic [REC_W-1:0]        record_bytes_reg;
    logic [DIVIDEND_W-1:0]   div_q_reg, div_q_next;
    logic [REM_W-1:0]        div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic [ROWS-1:0]         row_valid_reg, row_valid_next;
    logic [CAP_W-1:0]        filled_reg, filled_next;
    logic [2:0]              op_reg, op_next;
    logic [11:0]             slot_reg, slot_next;
    logic [ROW_AW-1:0]       row_reg, row_next;
    logic [1:0]              status_reg, status_next;
    logic [11:0]             found_reg, found_next;
    logic                    offs_en_reg, offs_en_next;
    logic                    hit_reg, hit_next;
    logic                    m_valid_reg, m_valid_next;
    psba_out_t               m_item_reg, m_item_next;

    logic                    cfg_hit;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [DIVISOR_W-1:0]    divisor;
    logic [REM_W-1:0]        rem_sh;
    logic                    rem_ge;
    logic [DIVIDEND_W-1:0]   q_step;
    logic [WORD_W-1:0]       word;
    logic [WORD_W-1:0]       zeros;
    logic                    has_zero;
    logic [BIT_W-1:0]        zbit;
    logic [BIT_W-1:0]        sel_bit;
    logic [WORD_W-1:0]       set_mask;
    logic [24:0]             prod;
    logic                    ram_we;
    logic [WORD_W-1:0]       ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;

    assign cfg_hit  = cfg_we && (cfg_index == CFG_PAGE_BYTES || cfg_index == CFG_RECORD_BYTES);
    assign dividend = (page_bytes_reg >= PAGE_MIN)
                    ? {page_bytes_reg, 3'b000} - HDR_BITS : '0;
    assign divisor  = {record_bytes_reg, 3'b000} + DIVISOR_W'(1);
    assign rem_sh   = {div_rem_reg[REM_W-2:0], div_q_reg[DIVIDEND_W-1]};
    assign rem_ge   = rem_sh >= REM_W'(divisor);
    assign q_step   = {div_q_reg[DIVIDEND_W-2:0], rem_ge};

    assign word     = row_valid_reg[row_reg] ? ram_rdata : '0;
    assign zeros    = ~word;
    assign has_zero = |zeros;

    always_comb begin
        zbit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (zeros[i]) begin
                zbit = BIT_W'(i);
            end
        end
    end

    assign sel_bit   = (state_reg == S_SCAN) ? zbit : slot_reg[BIT_W-1:0];
    assign set_mask  = WORD_W'(1) << sel_bit;
    assign ram_wdata = word | set_mask;
    assign prod      = 25'(found_reg) * 25'(record_bytes_reg);

    assign s_ready = (state_reg == S_IDLE) && !dirty_reg && !cfg_we;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        cap_next       = cap_reg;
        row_valid_next = row_valid_reg;
        filled_next    = filled_reg;
        op_next        = op_reg;
        slot_next      = slot_reg;
        row_next       = row_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        offs_en_next   = offs_en_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (dirty_reg) begin
                    div_q_next   = dividend;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    dirty_next   = 1'b0;
                    state_next   = S_DIV;
                end else if (s_valid && s_ready) begin
                    op_next      = s_item.opcode;
                    slot_next    = s_item.slot_sel;
                    status_next  = STAT_OK;
                    found_next   = '0;
                    offs_en_next = 1'b0;
                    hit_next     = 1'b0;
                    state_next   = S_DONE;
                    case (s_item.opcode)
                        OP_CLEAR: begin
                            row_valid_next = '0;
                            filled_next    = '0;
                        end
                        OP_ADD: begin
                            if (filled_reg >= cap_reg) begin
                                status_next = STAT_FULL;
                            end else begin
                                row_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_MARK, OP_QUERY: begin
                            found_next = s_item.slot_sel;
                            if (32'(s_item.slot_sel) >= 32'(cap_reg)) begin
                                status_next = STAT_RANGE;
                            end else begin
                                row_next   = ROW_AW'(s_item.slot_sel >> BIT_W);
                                state_next = S_MEM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                div_q_next   = q_step;
                div_rem_next = rem_ge ? rem_sh - REM_W'(divisor) : rem_sh;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    cap_next   = (q_step > DIVIDEND_W'(MAX_SLOTS))
                               ? CAP_W'(MAX_SLOTS) : CAP_W'(q_step);
                    state_next = S_IDLE;
                end
            end
            S_SCAN: begin
                if (has_zero) begin
                    ram_we                  = 1'b1;
                    row_valid_next[row_reg] = 1'b1;
                    filled_next             = filled_reg + 1'b1;
                    found_next              = 12'({row_reg, zbit});
                    offs_en_next            = 1'b1;
                    state_next              = S_DONE;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_MEM: begin
                offs_en_next = 1'b1;
                if (op_reg == OP_MARK) begin
                    if (!word[sel_bit]) begin
                        ram_we                  = 1'b1;
                        row_valid_next[row_reg] = 1'b1;
                        filled_next             = filled_reg + 1'b1;
                    end
                end else begin
                    hit_next = word[sel_bit];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_item_next.status        = status_reg;
                    m_item_next.slot_found    = found_reg;
                    m_item_next.byte_offset   = offs_en_reg ? prod[15:0] : '0;
                    m_item_next.slot_filled   = hit_reg;
                    m_item_next.free_count    = 13'(cap_reg - filled_reg);
                    m_item_next.slot_capacity = 13'(cap_reg);
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_hit) begin
            row_valid_next = '0;
            filled_next    = '0;
            dirty_next     = 1'b1;
            state_next     = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            dirty_reg        <= 1'b1;
            div_cnt_reg      <= '0;
            row_valid_reg    <= '0;
            filled_reg       <= '0;
            m_valid_reg      <= 1'b0;
            page_bytes_reg   <= PAGE_RST;
            record_bytes_reg <= REC_RST;
        end else begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            div_cnt_reg   <= div_cnt_next;
            row_valid_reg <= row_valid_next;
            filled_reg    <= filled_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we && cfg_index == CFG_PAGE_BYTES) begin
                page_bytes_reg <= cfg_wdata[PAGE_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_RECORD_BYTES) begin
                record_bytes_reg <= cfg_wdata[REC_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        cap_reg     <= cap_next;
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        row_reg     <= row_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        offs_en_reg <= offs_en_next;
        hit_reg     <= hit_next;
        m_item_reg  <= m_item_next;
    end

    psba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .raddr (row_next),
        .rdata (ram_rdata)
    );

    `PSBA_ASSERT_RST(a_reset_recalc, !aresetn |=> dirty_reg, "capacity not recomputed after reset")
    `PSBA_ASSERT(a_filled_le_cap, (!dirty_reg && state_reg != S_DIV) |-> filled_reg <= cap_reg, "filled slots exceed capacity")
    `PSBA_ASSERT(a_scan_bound, (state_reg == S_SCAN && row_reg == ROW_AW'(ROWS - 1)) |-> has_zero, "scan ran past last bitmap word")
    `PSBA_ASSERT(a_write_state, ram_we |-> (state_reg == S_SCAN || state_reg == S_MEM), "bitmap written outside scan or mark")
    `PSBA_ASSERT(a_filled_step, 1'b1 |=> (filled_reg == $past(filled_reg) || filled_reg == $past(filled_reg) + 1'b1 || filled_reg == '0), "filled count jumped")

endmodule

`default_nettype wire
